### rtl/rgbup_pkg.sv
// rgbup_pkg: shared types, constants and the channel blend function of the
// rgb565 2x by 5/3 upscaler; no dependencies

package rgbup_pkg;

  // default frame geometry
  localparam int unsigned InWidthDef    = 160;
  localparam int unsigned LineGroupsDef = 48;

  // field widths
  localparam int unsigned PixW    = 16;
  localparam int unsigned RowW    = 8;
  localparam int unsigned ColW    = 9;
  localparam int unsigned InDataW = 16;
  localparam int unsigned OutDataW = 40;

  // clears the low bit of every channel before halving
  localparam logic [PixW-1:0] HalfMask = 16'hf7de;

  // output row offsets inside a group of five
  localparam logic [RowW-1:0] RowOffUpper  = 8'd0;
  localparam logic [RowW-1:0] RowOffMiddle = 8'd1;
  localparam logic [RowW-1:0] RowOffBottom = 8'd3;
  localparam logic [RowW-1:0] RowsPerGroup = 8'd5;

  // position of an input line within its group of three
  typedef enum logic [1:0] {
    PH_UPPER  = 2'd0,
    PH_MIDDLE = 2'd1,
    PH_BOTTOM = 2'd2
  } phase_e;

  // one input item after column and row bookkeeping
  typedef struct packed {
    logic [PixW-1:0] pix;
    logic [RowW-1:0] row;   // first output row of this item
    logic [ColW-1:0] col;   // even output column
    logic            four;  // blended pair plus plain pair
  } item_t;

  // per channel floor(a/2)+floor(b/2), no carry between channels
  function automatic logic [PixW-1:0] blend565(input logic [PixW-1:0] a,
                                               input logic [PixW-1:0] b);
    logic [PixW-1:0] ha;
    logic [PixW-1:0] hb;
    ha = (a & HalfMask) >> 1;
    hb = (b & HalfMask) >> 1;
    return ha + hb;
  endfunction

endpackage

### rtl/rgb565_upscale_2x_by_5_3rds.sv
// rgb565_upscale_2x_by_5_3rds: top level of the 2x by 5/3 rgb565 upscaler
// depends on rgbup_pkg, rgbup_ram, rgbup_front, rgbup_emit
// an accepted item passes the front item register and then the emitter
//   registers, which present its first result once the emitter is free
// output: two pixels per upper-line item, four per middle or bottom item,
//   sent by the emitter one output pixel per cycle while m_axis_tready is high
// reset: counters return to the frame start; line buffer is not cleared

module rgb565_upscale_2x_by_5_3rds #(
  parameter int unsigned IN_WIDTH    = rgbup_pkg::InWidthDef,
  parameter int unsigned LINE_GROUPS = rgbup_pkg::LineGroupsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [rgbup_pkg::InDataW-1:0]  s_axis_tdata,   // [15:0] pixel_in
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] out_row, [16:8] out_col, [32:17] pixel_out, [39:33] zero
  output logic [rgbup_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                           m_axis_tlast    // last_of_run
);

  localparam int unsigned CW = $clog2(IN_WIDTH);

  logic                         take;
  logic                         item_valid;
  rgbup_pkg::item_t             item;
  logic                         ram_en;
  logic [CW-1:0]                ram_addr;
  logic [rgbup_pkg::PixW-1:0]   ram_wdata;
  logic [rgbup_pkg::PixW-1:0]   ram_rdata;

  // input counters and line buffer access
  rgbup_front #(
    .IN_WIDTH   (IN_WIDTH),
    .LINE_GROUPS(LINE_GROUPS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .take_i       (take),
    .valid_o      (item_valid),
    .item_o       (item),
    .ram_en_o     (ram_en),
    .ram_addr_o   (ram_addr),
    .ram_wdata_o  (ram_wdata)
  );

  // previous input line
  rgbup_ram #(
    .WIDTH(rgbup_pkg::PixW),
    .DEPTH(IN_WIDTH)
  ) u_line_buf (
    .clk_i  (clk_i),
    .we_i   (ram_en),
    .waddr_i(ram_addr),
    .wdata_i(ram_wdata),
    .re_i   (ram_en),
    .raddr_i(ram_addr),
    .rdata_o(ram_rdata)
  );

  // blend and result sequencing
  rgbup_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (item_valid),
    .item_i       (item),
    .prev_i       (ram_rdata),
    .take_o       (take),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

### rtl/rgbup_ram.sv
// rgbup_ram: generic simple dual port ram, one write and one registered read
// port, old data returned on a same-address read and write; no dependencies

module rgbup_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 160
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/rgbup_front.sv
// rgbup_front: input stage with column, line phase and group counters; it
// issues the line buffer access for each item; depends on rgbup_pkg

module rgbup_front #(
  parameter int unsigned IN_WIDTH    = rgbup_pkg::InWidthDef,
  parameter int unsigned LINE_GROUPS = rgbup_pkg::LineGroupsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rgbup_pkg::InDataW-1:0] s_axis_tdata,   // [15:0] pixel_in
  input  logic                          take_i,
  output logic                          valid_o,
  output rgbup_pkg::item_t              item_o,
  output logic                          ram_en_o,
  output logic [$clog2(IN_WIDTH)-1:0]   ram_addr_o,
  output logic [rgbup_pkg::PixW-1:0]    ram_wdata_o
);

  localparam int unsigned CW = $clog2(IN_WIDTH);
  localparam int unsigned GW = (LINE_GROUPS > 1) ? $clog2(LINE_GROUPS) : 1;
  localparam logic [CW-1:0] ColLast   = CW'(IN_WIDTH - 1);
  localparam logic [GW-1:0] GroupLast = GW'(LINE_GROUPS - 1);

  logic [CW-1:0]                col_q, col_d;
  rgbup_pkg::phase_e            phase_q, phase_d;
  logic [GW-1:0]                group_q, group_d;
  logic [rgbup_pkg::RowW-1:0]   base_q, base_d;
  logic                         valid_q, valid_d;
  rgbup_pkg::item_t             item_q, item_d;
  logic                         acc;
  logic [rgbup_pkg::RowW-1:0]   row_off;
  logic [CW+9:0]                col_wide;

  assign s_axis_tready = !valid_q || take_i;
  assign acc           = s_axis_tvalid && s_axis_tready;

  // line buffer: read old pixel and write new one at the same column
  assign ram_en_o    = acc;
  assign ram_addr_o  = col_q;
  assign ram_wdata_o = s_axis_tdata[rgbup_pkg::PixW-1:0];

  // row offset of the first result of this item
  always_comb begin
    case (phase_q)
      rgbup_pkg::PH_UPPER:  row_off = rgbup_pkg::RowOffUpper;
      rgbup_pkg::PH_MIDDLE: row_off = rgbup_pkg::RowOffMiddle;
      rgbup_pkg::PH_BOTTOM: row_off = rgbup_pkg::RowOffBottom;
      default:              row_off = rgbup_pkg::RowOffUpper;
    endcase
  end

  assign col_wide = (CW+10)'({col_q, 1'b0});

  // counter advance
  always_comb begin
    col_d   = col_q;
    phase_d = phase_q;
    group_d = group_q;
    base_d  = base_q;
    if (acc) begin
      if (col_q == ColLast) begin
        col_d = '0;
        case (phase_q)
          rgbup_pkg::PH_UPPER:  phase_d = rgbup_pkg::PH_MIDDLE;
          rgbup_pkg::PH_MIDDLE: phase_d = rgbup_pkg::PH_BOTTOM;
          default: begin
            phase_d = rgbup_pkg::PH_UPPER;
            if (group_q == GroupLast) begin
              group_d = '0;
              base_d  = '0;
            end else begin
              group_d = group_q + GW'(1);
              base_d  = base_q + rgbup_pkg::RowsPerGroup;
            end
          end
        endcase
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  // item register
  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (acc) begin
      valid_d     = 1'b1;
      item_d.pix  = s_axis_tdata[rgbup_pkg::PixW-1:0];
      item_d.row  = base_q + row_off;
      item_d.col  = col_wide[rgbup_pkg::ColW-1:0];
      item_d.four = (phase_q != rgbup_pkg::PH_UPPER);
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      phase_q <= rgbup_pkg::PH_UPPER;
      group_q <= '0;
      base_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      phase_q <= phase_d;
      group_q <= group_d;
      base_q  <= base_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### rtl/rgbup_emit.sv
// rgbup_emit: blends with the line buffer word and sends two or four output
// pixels per item, one per cycle while m_axis_tready is high; depends on rgbup_pkg

module rgbup_emit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  rgbup_pkg::item_t               item_i,
  input  logic [rgbup_pkg::PixW-1:0]     prev_i,
  output logic                           take_o,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] out_row, [16:8] out_col, [32:17] pixel_out, [39:33] zero
  output logic [rgbup_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                           m_axis_tlast   // last_of_run
);

  logic                         busy_q, busy_d;
  logic [1:0]                   step_q, step_d;
  logic [rgbup_pkg::RowW-1:0]   row_q, row_d;
  logic [rgbup_pkg::ColW-1:0]   col_q, col_d;
  logic [rgbup_pkg::PixW-1:0]   pix_q, pix_d;
  logic [rgbup_pkg::PixW-1:0]   mix_q, mix_d;
  logic                         four_q, four_d;
  logic                         last;
  logic                         done;
  logic [rgbup_pkg::RowW-1:0]   out_row;
  logic [rgbup_pkg::ColW-1:0]   out_col;
  logic [rgbup_pkg::PixW-1:0]   out_pix;

  assign last   = four_q ? (step_q == 2'd3) : (step_q == 2'd1);
  assign done   = busy_q && m_axis_tready && last;
  assign take_o = valid_i && (!busy_q || done);

  // load a new item or step through its results
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    row_d  = row_q;
    col_d  = col_q;
    pix_d  = pix_q;
    mix_d  = mix_q;
    four_d = four_q;
    if (take_o) begin
      busy_d = 1'b1;
      step_d = 2'd0;
      row_d  = item_i.row;
      col_d  = item_i.col;
      pix_d  = item_i.pix;
      mix_d  = rgbup_pkg::blend565(prev_i, item_i.pix);
      four_d = item_i.four;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (busy_q && m_axis_tready) begin
      step_d = step_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= 2'd0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q  <= row_d;
    col_q  <= col_d;
    pix_q  <= pix_d;
    mix_q  <= mix_d;
    four_q <= four_d;
  end

  // result fields from the current step
  assign out_row = step_q[1] ? row_q + rgbup_pkg::RowW'(1) : row_q;
  assign out_col = {col_q[rgbup_pkg::ColW-1:1], step_q[0]};
  assign out_pix = (four_q && !step_q[1]) ? mix_q : pix_q;

  assign m_axis_tvalid = busy_q;
  assign m_axis_tlast  = last;
  assign m_axis_tdata  = {7'd0, out_pix, out_col, out_row};

endmodule

### dv/upscale_checker.sv
`timescale 1ns / 1ps
// upscale_checker: watches both streams of the rgb565 2x by 5/3 upscaler,
// predicts the output pixels of every accepted input item and compares them
// depends on rgbup_pkg for widths, row offsets and line phases

module upscale_checker #(
  parameter int unsigned IN_WIDTH    = rgbup_pkg::InWidthDef,
  parameter int unsigned LINE_GROUPS = rgbup_pkg::LineGroupsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [rgbup_pkg::InDataW-1:0]  in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [rgbup_pkg::OutDataW-1:0] out_data_i,
  input  logic                           out_last_i,
  output int unsigned                    mismatches_o,
  output int unsigned                    outstanding_o
);

  localparam int unsigned PixW     = rgbup_pkg::PixW;
  localparam int unsigned RowW     = rgbup_pkg::RowW;
  localparam int unsigned ColW     = rgbup_pkg::ColW;
  localparam int unsigned OutDataW = rgbup_pkg::OutDataW;

  // one predicted output pixel
  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic [PixW-1:0] pix;
    logic            last;
  } out_pix_t;

  out_pix_t            expected_pixels[$];
  logic [PixW-1:0]     line_buf [IN_WIDTH];
  int unsigned         col_cnt;
  int unsigned         grp_cnt;
  rgbup_pkg::phase_e   phase;
  int unsigned         mismatches;

  // channel-wise average of two rgb565 pixels, each half rounded down
  function automatic logic [PixW-1:0] mix_pixels(input logic [PixW-1:0] a,
                                                 input logic [PixW-1:0] b);
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] bl;
    r  = (a[15:11] >> 1) + (b[15:11] >> 1);
    g  = (a[10:5] >> 1) + (b[10:5] >> 1);
    bl = (a[4:0] >> 1) + (b[4:0] >> 1);
    return {r, g, bl};
  endfunction

  // every output pixel appears at columns 2c and 2c+1
  task automatic push_pair(input int unsigned row, input int unsigned col,
                           input logic [PixW-1:0] pix, input logic ends_item);
    out_pix_t p;
    p.row  = RowW'(row);
    p.col  = ColW'(col);
    p.pix  = pix;
    p.last = 1'b0;
    expected_pixels.push_back(p);
    p.col  = ColW'(col + 1);
    p.last = ends_item;
    expected_pixels.push_back(p);
  endtask

  // output pixels of one input item, then line buffer and counter update
  task automatic upscale_pixel(input logic [PixW-1:0] pix);
    int unsigned base;
    int unsigned off;
    base = 32'(rgbup_pkg::RowsPerGroup) * grp_cnt;
    if (phase == rgbup_pkg::PH_UPPER) begin
      push_pair(base + 32'(rgbup_pkg::RowOffUpper), 2 * col_cnt, pix, 1'b1);
    end else begin
      off = 32'((phase == rgbup_pkg::PH_MIDDLE) ? rgbup_pkg::RowOffMiddle
                                                : rgbup_pkg::RowOffBottom);
      push_pair(base + off, 2 * col_cnt, mix_pixels(line_buf[col_cnt], pix), 1'b0);
      push_pair(base + off + 1, 2 * col_cnt, pix, 1'b1);
    end
    line_buf[col_cnt] = pix;
    col_cnt++;
    if (col_cnt >= IN_WIDTH) begin
      col_cnt = 0;
      case (phase)
        rgbup_pkg::PH_UPPER:  phase = rgbup_pkg::PH_MIDDLE;
        rgbup_pkg::PH_MIDDLE: phase = rgbup_pkg::PH_BOTTOM;
        default: begin
          phase = rgbup_pkg::PH_UPPER;
          grp_cnt++;
          if (grp_cnt >= LINE_GROUPS) grp_cnt = 0;
        end
      endcase
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // predict on input items, compare on output items
  always @(posedge clk_i or negedge rst_ni) begin
    out_pix_t want;
    if (!rst_ni) begin
      expected_pixels.delete();
      col_cnt    = 0;
      grp_cnt    = 0;
      phase      = rgbup_pkg::PH_UPPER;
      mismatches = 0;
    end else begin
      if (in_valid_i && in_ready_i) upscale_pixel(in_data_i[PixW-1:0]);
      if (out_valid_i && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected output item: row %0d col %0d pixel 0x%0h",
                 out_data_i[7:0], out_data_i[16:8], out_data_i[32:17]);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("out_row", 32'(want.row), 32'(out_data_i[7:0]));
          check_field("out_col", 32'(want.col), 32'(out_data_i[16:8]));
          check_field("pixel_out", 32'(want.pix), 32'(out_data_i[32:17]));
          check_field("last_of_run", 32'(want.last), 32'(out_last_i));
          check_field("tdata padding", 0, 32'(out_data_i[OutDataW-1:33]));
        end
      end
    end
    mismatches_o  <= mismatches;
    outstanding_o <= expected_pixels.size();
  end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// tb: stimulus and verdict for rgb565_upscale_2x_by_5_3rds; streams two full
// lines and the start of a third, with random idling on both sides
// depends on rgbup_pkg, the upscaler rtl and dv/upscale_checker.sv

module tb;

  localparam int unsigned InWidth    = rgbup_pkg::InWidthDef;
  localparam int unsigned LineGroups = rgbup_pkg::LineGroupsDef;
  localparam int unsigned PixW       = rgbup_pkg::PixW;
  localparam int unsigned InDataW    = rgbup_pkg::InDataW;
  localparam int unsigned OutDataW   = rgbup_pkg::OutDataW;
  localparam int unsigned TotalPix   = 2 * InWidth + 30;
  localparam int unsigned CornerCnt  = 24;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // [15:0] pixel_in
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // [7:0] out_row, [16:8] out_col, [32:17] pixel_out, [39:33] zero
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;   // last_of_run
  int unsigned         mismatches;
  int unsigned         outstanding;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  rgb565_upscale_2x_by_5_3rds #(
    .IN_WIDTH    (InWidth),
    .LINE_GROUPS (LineGroups)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  upscale_checker #(
    .IN_WIDTH    (InWidth),
    .LINE_GROUPS (LineGroups)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_i    (s_axis_tready),
    .in_data_i     (s_axis_tdata),
    .out_valid_i   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_i    (m_axis_tdata),
    .out_last_i    (m_axis_tlast),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  // channel extremes and low-bit patterns that stress the blend
  function automatic logic [PixW-1:0] corner_pixel(input int unsigned k);
    case (k)
      0:  return 16'h0000;
      1:  return 16'hffff;
      2:  return 16'hf7de;
      3:  return 16'h0821;
      4:  return 16'h8410;
      5:  return 16'h7bef;
      6:  return 16'hf800;
      7:  return 16'h07e0;
      8:  return 16'h001f;
      9:  return 16'h0001;
      10: return 16'h8000;
      11: return 16'h5555;
      12: return 16'haaaa;
      13: return 16'hffdf;
      14: return 16'hf81f;
      15: return 16'h07ff;
      16: return 16'hffe0;
      17: return 16'h0020;
      18: return 16'h0800;
      19: return 16'h1084;
      20: return 16'hef7b;
      21: return 16'h3ce7;
      22: return 16'hc318;
      23: return 16'h0842;
      default: return 16'h0000;
    endcase
  endfunction

  // directed corners at the start of the first three lines, then mostly random
  function automatic logic [PixW-1:0] pick_pixel(input int unsigned n);
    int unsigned line;
    int unsigned col;
    line = n / InWidth;
    col  = n % InWidth;
    if (line < 3 && col < CornerCnt) return corner_pixel((col + 7 * line) % CornerCnt);
    if ($urandom_range(0, 3) == 0) return corner_pixel($urandom_range(0, CornerCnt - 1));
    return PixW'($urandom);
  endfunction

  // sender
  initial begin
    int unsigned gap;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int unsigned n = 0; n < TotalPix; n++) begin
      gap = $urandom_range(0, 13);
      // drain everything once after the directed corners of the first line
      if (n == CornerCnt) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (outstanding != 0);
      end
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= pick_pixel(n);
      do @(posedge clk_i); while (!s_axis_tready);
    end
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // receiver with random back-pressure per output item
  initial begin
    int unsigned stall;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 13);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
